/* rtl/tach_led_bar_graph_core_defines.svh */
// assertion macros for the tach led bar graph core
// used by tlbg_div and tach_led_bar_graph_core; expects clk and arst_n in scope
`ifndef TACH_LED_BAR_GRAPH_CORE_DEFINES_SVH
`define TACH_LED_BAR_GRAPH_CORE_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define TLBG_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define TLBG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TLBG_ASSERT(label, ante, cons, msg)
`define TLBG_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* rtl/tlbg_pkg.sv */
// shared types, constants and helper functions for the tach led bar graph core
// no dependencies; used by tlbg_div, tlbg_pixel and tach_led_bar_graph_core
`timescale 1ns / 1ps

package tlbg_pkg;

	// bar geometry
	localparam int LED_COUNT = 16;
	localparam int LED_W = $clog2(LED_COUNT);
	localparam int IDX_OUT_W = 6;

	// field widths
	localparam int RPM_W = 15;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_ADDR_W = 3;

	// fill level in q8 leds, and the dividend that produces it
	localparam int FILL_W = $clog2(LED_COUNT * 256 + 1);
	localparam int DIVIDEND_W = RPM_W + LED_W + 8;
	localparam int DIV_CNT_W = $clog2(FILL_W + 1);

	// register indexes
	localparam logic [CFG_ADDR_W-1:0] CFG_MIN_RPM      = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_FLASH_RPM    = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_BRIGHTNESS   = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_RAINBOW_MODE = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_FLASH_PERIOD = 3'd4;

	// register reset values
	localparam logic [RPM_W-1:0] MIN_RPM_RST      = 15'd0;
	localparam logic [RPM_W-1:0] FLASH_RPM_RST    = 15'd12000;
	localparam logic [7:0]       BRIGHTNESS_RST   = 8'd255;
	localparam logic [15:0]      FLASH_PERIOD_RST = 16'd50;

	// color constants
	localparam int HUE_SECTOR = 43;
	localparam int FADE_SPAN = 256;
	localparam logic [16:0] ORANGE_GREEN_MUL = 17'd150;
	// x / 10 == (x * 205) >> 11 for any 8-bit x
	localparam logic [16:0] DIM_MUL = 17'd205;
	localparam int DIM_SHIFT = 11;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_PIX1,
		ST_PIX2,
		ST_PIX3
	} state_t;

	// how one led is colored
	typedef enum logic [2:0] {
		PIX_BLACK,
		PIX_FULL,
		PIX_FADE,
		PIX_DIM,
		PIX_ORANGE
	} pix_class_t;

	typedef struct packed {
		logic s1_en;
		logic s2_en;
		logic flashing;
		logic flash_on;
		logic rainbow;
	} pix_ctrl_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [RPM_W-1:0] engine_rpm;
		logic [7:0]       hue_offset;
	} in_item_t;

	typedef struct packed {
		logic [IDX_OUT_W-1:0] led_index;
		logic [7:0]           red;
		logic [7:0]           green;
		logic [7:0]           blue;
		logic                 last_led;
	} out_item_t;

	// hue sector 0..5, one compare per sector boundary
	function automatic logic [2:0] hue_region(input logic [7:0] h);
		logic [2:0] r;
		r = 3'd0;
		for (int k = 1; k < 6; k++) begin
			if (h >= 8'(HUE_SECTOR * k)) begin
				r = 3'(k);
			end
		end
		return r;
	endfunction

	// 255 - ((255 * x) >> 8)
	function automatic logic [7:0] hsv_fall(input logic [7:0] x);
		logic [15:0] p;
		p = 16'(x) * 16'd255;
		return 8'd255 - p[15:8];
	endfunction

endpackage

/* rtl/tach_led_bar_graph_core.sv */
// tach led bar graph: one frame item in, one pixel item per led out (led 0 first)
// sequence: the accept, the divider when the speed is inside the fill range, then the
// three-step pixel datapath for each led; a new frame is accepted only from idle, after
// the last led's item is loaded; the frame rate is set by the single one-bit-per-cycle
// divider and the three-step pixel sequence, and output stalls slow it further
// arst_n sets the configuration registers to their reset values, flash phase to 0, no output pending
`timescale 1ns / 1ps
`include "tach_led_bar_graph_core_defines.svh"

module tach_led_bar_graph_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  tlbg_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output tlbg_pkg::out_item_t                 out_data,
	input  logic                                cfg_we,
	input  logic [tlbg_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [tlbg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	// configuration registers
	logic [tlbg_pkg::RPM_W-1:0]     min_rpm_q;
	logic [tlbg_pkg::RPM_W-1:0]     flash_rpm_q;
	logic [7:0]                     brightness_q;
	logic                           rainbow_q;
	logic [15:0]                    flash_period_q;

	// frame state
	tlbg_pkg::state_t               state_q;
	tlbg_pkg::state_t               state_d;
	logic [15:0]                    flash_phase_q;
	logic                           flashing_q;
	logic                           flash_on_q;
	logic [7:0]                     hue_off_q;
	logic [tlbg_pkg::FILL_W-1:0]    fill_q;
	logic [tlbg_pkg::LED_W-1:0]     led_idx_q;
	logic                           out_valid_q;
	tlbg_pkg::out_item_t            out_q;

	logic                           accept_w;
	logic                           div_start_w;
	logic                           out_load_w;
	logic                           last_w;
	logic                           flashing_w;
	logic                           need_div_w;
	logic [15:0]                    phase_inc_w;
	logic [15:0]                    phase_next_w;
	logic                           flash_on_w;
	logic [tlbg_pkg::DIVIDEND_W-1:0] dividend_w;
	logic [tlbg_pkg::RPM_W-1:0]     divisor_w;
	logic                           div_done_w;
	logic [tlbg_pkg::FILL_W-1:0]    div_quot_w;
	tlbg_pkg::pix_ctrl_t            pix_ctrl_w;
	tlbg_pkg::rgb_t                 pix_w;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_rpm_q      <= tlbg_pkg::MIN_RPM_RST;
			flash_rpm_q    <= tlbg_pkg::FLASH_RPM_RST;
			brightness_q   <= tlbg_pkg::BRIGHTNESS_RST;
			rainbow_q      <= 1'b0;
			flash_period_q <= tlbg_pkg::FLASH_PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				tlbg_pkg::CFG_MIN_RPM:      min_rpm_q      <= cfg_wdata[tlbg_pkg::RPM_W-1:0];
				tlbg_pkg::CFG_FLASH_RPM:    flash_rpm_q    <= cfg_wdata[tlbg_pkg::RPM_W-1:0];
				tlbg_pkg::CFG_BRIGHTNESS:   brightness_q   <= cfg_wdata[7:0];
				tlbg_pkg::CFG_RAINBOW_MODE: rainbow_q      <= cfg_wdata[0];
				tlbg_pkg::CFG_FLASH_PERIOD: flash_period_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// frame decode: flash phase advance, flash test and divider operands
	always_comb begin
		flashing_w   = in_data.engine_rpm > flash_rpm_q;
		need_div_w   = !flashing_w && (in_data.engine_rpm > min_rpm_q);
		phase_inc_w  = flash_phase_q + 16'd1;
		phase_next_w = (phase_inc_w >= flash_period_q) ? 16'd0 : phase_inc_w;
		flash_on_w   = {phase_next_w, 1'b0} > {1'b0, flash_period_q};
		dividend_w   = (tlbg_pkg::DIVIDEND_W'(tlbg_pkg::RPM_W'(in_data.engine_rpm - min_rpm_q))
			* tlbg_pkg::DIVIDEND_W'(tlbg_pkg::LED_COUNT)) << 8;
		divisor_w    = tlbg_pkg::RPM_W'(flash_rpm_q - min_rpm_q);
		last_w       = led_idx_q == tlbg_pkg::LED_W'(tlbg_pkg::LED_COUNT - 1);
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tlbg_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = need_div_w ? tlbg_pkg::ST_DIV : tlbg_pkg::ST_PIX1;
				end
			end
			tlbg_pkg::ST_DIV: begin
				if (div_done_w) begin
					state_d = tlbg_pkg::ST_PIX1;
				end
			end
			tlbg_pkg::ST_PIX1: state_d = tlbg_pkg::ST_PIX2;
			tlbg_pkg::ST_PIX2: state_d = tlbg_pkg::ST_PIX3;
			tlbg_pkg::ST_PIX3: begin
				if (out_load_w) begin
					state_d = last_w ? tlbg_pkg::ST_IDLE : tlbg_pkg::ST_PIX1;
				end
			end
			default: state_d = tlbg_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready            = state_q == tlbg_pkg::ST_IDLE;
		accept_w            = in_ready && in_valid;
		div_start_w         = accept_w && need_div_w;
		out_load_w          = (state_q == tlbg_pkg::ST_PIX3) && (!out_valid_q || out_ready);
		pix_ctrl_w.s1_en    = state_q == tlbg_pkg::ST_PIX1;
		pix_ctrl_w.s2_en    = state_q == tlbg_pkg::ST_PIX2;
		pix_ctrl_w.flashing = flashing_q;
		pix_ctrl_w.flash_on = flash_on_q;
		pix_ctrl_w.rainbow  = rainbow_q;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= tlbg_pkg::ST_IDLE;
			flash_phase_q <= '0;
			led_idx_q     <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept_w) begin
				flash_phase_q <= phase_next_w;
			end
			if (out_load_w) begin
				led_idx_q <= last_w ? '0 : led_idx_q + 1'b1;
			end
			if (out_load_w) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// frame and output payload
	always_ff @(posedge clk) begin
		if (accept_w) begin
			flashing_q <= flashing_w;
			flash_on_q <= flash_on_w;
			hue_off_q  <= in_data.hue_offset;
			fill_q     <= '0;
		end else if (div_done_w && state_q == tlbg_pkg::ST_DIV) begin
			fill_q <= div_quot_w;
		end
		if (out_load_w) begin
			out_q.led_index <= tlbg_pkg::IDX_OUT_W'(led_idx_q);
			out_q.red       <= pix_w.red;
			out_q.green     <= pix_w.green;
			out_q.blue      <= pix_w.blue;
			out_q.last_led  <= last_w;
		end
	end

	tlbg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_w),
		.dividend (dividend_w),
		.divisor  (divisor_w),
		.done     (div_done_w),
		.quotient (div_quot_w)
	);

	tlbg_pixel u_pixel (
		.clk        (clk),
		.ctrl       (pix_ctrl_w),
		.fill       (fill_q),
		.led_idx    (led_idx_q),
		.brightness (brightness_q),
		.hue_offset (hue_off_q),
		.pix        (pix_w)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`TLBG_ASSERT(a_idle_idx_zero, state_q == tlbg_pkg::ST_IDLE, led_idx_q == '0, "led counter not rewound at frame end")
	`TLBG_ASSERT(a_pending_not_idle, out_valid_q && !out_q.last_led, state_q != tlbg_pkg::ST_IDLE, "frame ended before its last pixel item")
	`TLBG_ASSERT(a_fill_bound, div_done_w, div_quot_w <= tlbg_pkg::FILL_W'(tlbg_pkg::LED_COUNT * 256), "fill level above full bar")

endmodule

/* rtl/tlbg_div.sv */
// iterative restoring divider producing the q8 fill level, one quotient bit per cycle
// depends on tlbg_pkg and tach_led_bar_graph_core_defines.svh
`timescale 1ns / 1ps
`include "tach_led_bar_graph_core_defines.svh"

module tlbg_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [tlbg_pkg::DIVIDEND_W-1:0]      dividend,
	input  logic [tlbg_pkg::RPM_W-1:0]           divisor,
	output logic                                 done,
	output logic [tlbg_pkg::FILL_W-1:0]          quotient
);

	logic                                busy_q;
	logic                                done_q;
	logic [tlbg_pkg::DIV_CNT_W-1:0]      cnt_q;
	logic [tlbg_pkg::RPM_W-1:0]          rem_q;
	logic [tlbg_pkg::RPM_W-1:0]          dvs_q;
	logic [tlbg_pkg::FILL_W-1:0]         sh_q;

	logic [tlbg_pkg::RPM_W:0]            trial_w;
	logic [tlbg_pkg::RPM_W:0]            diff_w;
	logic                                ge_w;

	// trial subtract of the shifted partial remainder
	always_comb begin
		trial_w = {rem_q, sh_q[tlbg_pkg::FILL_W-1]};
		ge_w    = trial_w >= {1'b0, dvs_q};
		diff_w  = trial_w - {1'b0, dvs_q};
	end

	// control: step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= tlbg_pkg::DIV_CNT_W'(tlbg_pkg::FILL_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == tlbg_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: upper dividend bits start as the remainder, quotient shifts in low
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= tlbg_pkg::RPM_W'(dividend >> tlbg_pkg::FILL_W);
			sh_q  <= dividend[tlbg_pkg::FILL_W-1:0];
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge_w ? diff_w[tlbg_pkg::RPM_W-1:0] : trial_w[tlbg_pkg::RPM_W-1:0];
			sh_q  <= {sh_q[tlbg_pkg::FILL_W-2:0], ge_w};
		end
	end

	assign done     = done_q;
	assign quotient = sh_q;

	`TLBG_ASSERT(a_rem_below_divisor, busy_q && cnt_q != tlbg_pkg::DIV_CNT_W'(tlbg_pkg::FILL_W), rem_q < dvs_q, "partial remainder reached the divisor")
	`TLBG_ASSERT_NEXT(a_start_goes_busy, start && !busy_q, busy_q && !done_q, "divider did not start")
	`TLBG_ASSERT(a_done_ends_run, done_q, !busy_q && cnt_q == '0, "done while still iterating")

endmodule

/* rtl/tlbg_pixel.sv */
// per-led color datapath (depends on tlbg_pkg): classify and hue, value
// scale, hsv to rgb; sequencer steps one stage per cycle if not stalled
`timescale 1ns / 1ps

module tlbg_pixel (
	input  logic                             clk,
	input  tlbg_pkg::pix_ctrl_t              ctrl,
	input  logic [tlbg_pkg::FILL_W-1:0]      fill,
	input  logic [tlbg_pkg::LED_W-1:0]       led_idx,
	input  logic [7:0]                       brightness,
	input  logic [7:0]                       hue_offset,
	output tlbg_pkg::rgb_t                   pix
);

	localparam int EXC_W = tlbg_pkg::FILL_W + 1;
	localparam logic signed [EXC_W-1:0] SPAN_S = EXC_W'(tlbg_pkg::FADE_SPAN);
	localparam logic signed [EXC_W-1:0] ZERO_S = '0;

	// stage 1 registers
	tlbg_pkg::pix_class_t        cls_s1;
	logic [8:0]                  e_s1;
	logic [16:0]                 esq_s1;
	logic [2:0]                  region_s1;
	logic [7:0]                  fq_s1;
	logic [7:0]                  ft_s1;

	// stage 2 registers
	tlbg_pkg::pix_class_t        cls_s2;
	logic [7:0]                  v_s2;
	logic [15:0]                 aux_s2;

	logic [tlbg_pkg::FILL_W-1:0] nled_w;
	logic [tlbg_pkg::FILL_W-1:0] need_w;
	logic signed [EXC_W-1:0]     excess_w;
	logic [7:0]                  hue_w;
	logic [2:0]                  region_w;
	logic [7:0]                  rem_w;
	tlbg_pkg::pix_class_t        cls_w;

	// excess over this led's threshold, hue and class
	always_comb begin
		nled_w   = tlbg_pkg::FILL_W'(tlbg_pkg::LED_COUNT) - tlbg_pkg::FILL_W'(led_idx);
		need_w   = nled_w << 8;
		excess_w = $signed({1'b0, fill}) - $signed({1'b0, need_w});
		hue_w    = ctrl.rainbow ? ((8'(led_idx) << 4) + hue_offset) : (8'(led_idx) << 2);
		region_w = tlbg_pkg::hue_region(hue_w);
		rem_w    = 8'((hue_w - 8'(region_w * 8'(tlbg_pkg::HUE_SECTOR))) * 8'd6);
		if (ctrl.flashing) begin
			if (!ctrl.flash_on) begin
				cls_w = tlbg_pkg::PIX_BLACK;
			end else if (ctrl.rainbow) begin
				cls_w = tlbg_pkg::PIX_FULL;
			end else begin
				cls_w = tlbg_pkg::PIX_ORANGE;
			end
		end else if (excess_w > SPAN_S) begin
			cls_w = tlbg_pkg::PIX_FULL;
		end else if (excess_w > ZERO_S) begin
			cls_w = tlbg_pkg::PIX_FADE;
		end else if (ctrl.rainbow) begin
			cls_w = tlbg_pkg::PIX_DIM;
		end else begin
			cls_w = tlbg_pkg::PIX_BLACK;
		end
	end

	// stage 1: square of the excess and hsv ramp factors
	always_ff @(posedge clk) begin
		if (ctrl.s1_en) begin
			cls_s1    <= cls_w;
			e_s1      <= excess_w[8:0];
			esq_s1    <= 17'(excess_w[8:0]) * 17'(excess_w[8:0]);
			region_s1 <= region_w;
			fq_s1     <= tlbg_pkg::hsv_fall(rem_w);
			ft_s1     <= tlbg_pkg::hsv_fall(8'd255 - rem_w);
		end
	end

	logic [16:0] op_w;
	logic [24:0] prod_w;
	logic [7:0]  v_w;

	// stage 2: one brightness multiplier, operand picked by class
	always_comb begin
		unique case (cls_s1)
			tlbg_pkg::PIX_FADE:   op_w = ctrl.rainbow ? 17'(e_s1) : esq_s1;
			tlbg_pkg::PIX_DIM:    op_w = tlbg_pkg::DIM_MUL;
			tlbg_pkg::PIX_ORANGE: op_w = tlbg_pkg::ORANGE_GREEN_MUL;
			default:              op_w = 17'd1;
		endcase
		prod_w = 25'(brightness) * 25'(op_w);
		unique case (cls_s1)
			tlbg_pkg::PIX_FULL,
			tlbg_pkg::PIX_ORANGE: v_w = brightness;
			tlbg_pkg::PIX_FADE:   v_w = ctrl.rainbow ? 8'(prod_w >> 8) : 8'(prod_w >> 16);
			tlbg_pkg::PIX_DIM:    v_w = 8'(prod_w >> tlbg_pkg::DIM_SHIFT);
			default:              v_w = 8'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.s2_en) begin
			cls_s2 <= cls_s1;
			v_s2   <= v_w;
			aux_s2 <= prod_w[15:0];
		end
	end

	logic [15:0] q_prod_w;
	logic [15:0] t_prod_w;
	logic [7:0]  q_w;
	logic [7:0]  t_w;
	logic [15:0] div255_w;

	// stage 3: hsv sector mapping, the fixed orange, or black
	always_comb begin
		q_prod_w = 16'(v_s2) * 16'(fq_s1);
		t_prod_w = 16'(v_s2) * 16'(ft_s1);
		q_w      = q_prod_w[15:8];
		t_w      = t_prod_w[15:8];
		// exact floor(x / 255) for 16-bit x below 65280
		div255_w = (aux_s2 + 16'd1 + (aux_s2 >> 8)) >> 8;
		pix = '0;
		case (cls_s2)
			tlbg_pkg::PIX_BLACK: begin
				pix = '0;
			end
			tlbg_pkg::PIX_ORANGE: begin
				pix.red   = v_s2;
				pix.green = div255_w[7:0];
				pix.blue  = 8'd0;
			end
			default: begin
				case (region_s1)
					3'd0:    pix = '{red: v_s2, green: t_w,  blue: 8'd0};
					3'd1:    pix = '{red: q_w,  green: v_s2, blue: 8'd0};
					3'd2:    pix = '{red: 8'd0, green: v_s2, blue: t_w};
					3'd3:    pix = '{red: 8'd0, green: q_w,  blue: v_s2};
					3'd4:    pix = '{red: t_w,  green: 8'd0, blue: v_s2};
					default: pix = '{red: v_s2, green: 8'd0, blue: q_w};
				endcase
			end
		endcase
	end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// self-checking bench for tach_led_bar_graph_core: a directed frame table, then random frames
// under several register settings, each pixel item checked against a behavioral model
// depends on tlbg_pkg and the core rtl only

module testbench;
	import tlbg_pkg::*;

	localparam int SETTLE_CYCLES = 100;
	localparam int HOLD_CYCLES = 400;
	localparam int RAND_PHASES = 6;
	localparam int ITEMS_PER_PHASE = 70;
	localparam int MAX_REPORTS = 200;

	typedef enum bit {
		ROW_ITEM,
		ROW_CFG
	} row_kind_t;

	// one line of the directed table: a register write or a frame item
	typedef struct packed {
		row_kind_t             kind;
		bit [CFG_ADDR_W-1:0]   addr;
		bit [CFG_DATA_W-1:0]   data;
		bit [RPM_W-1:0]        rpm;
		bit [7:0]              hue;
		bit                    blank;
	} stim_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	in_item_t               in_data = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	out_item_t              out_data;
	logic                   cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

	// register shadow and flash phase of the model
	logic [RPM_W-1:0]       min_rpm_r;
	logic [RPM_W-1:0]       flash_rpm_r;
	logic [7:0]             bright_r;
	logic                   rainbow_r;
	logic [15:0]            period_r;
	logic [15:0]            phase_r;

	out_item_t              pixel_q [$];
	stim_row_t              frame_table [$];
	int unsigned            fail_count = 0;
	int unsigned            burst_left = 0;
	bit                     hold_req = 1'b0;

	tach_led_bar_graph_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// 8-bit hsv to rgb at full saturation
	function automatic rgb_t hsv_full(input logic [7:0] h, input logic [7:0] v);
		int unsigned region, rem, q, t;
		rgb_t c;
		region = h / HUE_SECTOR;
		rem = ((h - region * HUE_SECTOR) * 6) & 8'hFF;
		q = (v * (255 - ((255 * rem) >> 8))) >> 8;
		t = (v * (255 - ((255 * (255 - rem)) >> 8))) >> 8;
		case (region)
			0: c = {v, 8'(t), 8'd0};
			1: c = {8'(q), v, 8'd0};
			2: c = {8'd0, v, 8'(t)};
			3: c = {8'd0, 8'(q), v};
			4: c = {8'(t), 8'd0, v};
			default: c = {v, 8'd0, 8'(q)};
		endcase
		return c;
	endfunction

	// advance the flash phase and queue the pixels of one frame
	task automatic predict_frame(input logic [RPM_W-1:0] rpm, input logic [7:0] hue_off,
			input bit blank);
		int fill, excess;
		logic flashing, flash_on;
		logic [7:0] hue, v;
		rgb_t c;
		out_item_t px;
		flashing = rpm > flash_rpm_r;
		phase_r = phase_r + 16'd1;
		if (phase_r >= period_r) begin
			phase_r = '0;
		end
		flash_on = (int'(phase_r) * 2) > int'(period_r);
		fill = 0;
		if (!flashing && rpm > min_rpm_r) begin
			fill = ((int'(rpm) - int'(min_rpm_r)) * LED_COUNT * 256)
				/ (int'(flash_rpm_r) - int'(min_rpm_r));
		end
		for (int i = 0; i < LED_COUNT; i++) begin
			hue = rainbow_r ? 8'(i * 16 + hue_off) : 8'(i * 4);
			c = '0;
			if (flashing) begin
				if (flash_on) begin
					if (rainbow_r) begin
						c = hsv_full(hue, bright_r);
					end else begin
						c = {bright_r, 8'((150 * bright_r) / 255), 8'd0};
					end
				end
			end else begin
				excess = fill - (LED_COUNT - i) * 256;
				if (excess > 256) begin
					c = hsv_full(hue, bright_r);
				end else if (excess > 0) begin
					if (rainbow_r) begin
						v = 8'((int'(bright_r) * excess) >> 8);
					end else begin
						v = 8'((int'(bright_r) * excess * excess) >> 16);
					end
					c = hsv_full(hue, v);
				end else if (rainbow_r) begin
					c = hsv_full(hue, 8'(bright_r / 10));
				end
			end
			// rows typed as dark override the computed color
			if (blank) begin
				c = '0;
			end
			px.led_index = IDX_OUT_W'(i);
			px.red = c.red;
			px.green = c.green;
			px.blue = c.blue;
			px.last_led = (i == LED_COUNT - 1);
			pixel_q.push_back(px);
		end
	endtask

	// register write, left asserted for back-to-back writes
	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_MIN_RPM:      min_rpm_r = val[RPM_W-1:0];
			CFG_FLASH_RPM:    flash_rpm_r = val[RPM_W-1:0];
			CFG_BRIGHTNESS:   bright_r = val[7:0];
			CFG_RAINBOW_MODE: rainbow_r = val[0];
			CFG_FLASH_PERIOD: period_r = val[15:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// offer one frame item, then a burst gap now and then
	task automatic send_item(input logic [RPM_W-1:0] rpm, input logic [7:0] hue_off,
			input bit blank);
		int unsigned gap;
		in_valid <= 1'b1;
		in_data <= '{engine_rpm: rpm, hue_offset: hue_off};
		do @(posedge clk); while (!in_ready);
		predict_frame(rpm, hue_off, blank);
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = $urandom_range(1, 90);
		end else begin
			burst_left--;
		end
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop offering, wait for every pixel, then let the core go quiet
	task automatic drain_and_settle();
		in_valid <= 1'b0;
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// random register settings, extremes included
	task automatic pick_settings();
		int lo, hi, lvl, per;
		case ($urandom_range(0, 5))
			0: lo = 0;
			1: lo = 32767;
			default: lo = $urandom_range(0, 30000);
		endcase
		case ($urandom_range(0, 5))
			0: hi = 32767;
			1: hi = (lo < 32767) ? lo + 1 : 32767;
			2: hi = $urandom_range(1, 32767);
			default: hi = (lo < 32767) ? $urandom_range(lo + 1, 32767) : 32767;
		endcase
		case ($urandom_range(0, 3))
			0: lvl = 0;
			1: lvl = 255;
			default: lvl = $urandom_range(0, 255);
		endcase
		case ($urandom_range(0, 7))
			0: per = $urandom_range(0, 1);
			1: per = 65535;
			2: per = 2;
			3: per = $urandom_range(2, 65535);
			default: per = $urandom_range(3, 12);
		endcase
		write_reg(CFG_MIN_RPM, CFG_DATA_W'(lo));
		write_reg(CFG_FLASH_RPM, CFG_DATA_W'(hi));
		write_reg(CFG_BRIGHTNESS, CFG_DATA_W'(lvl));
		write_reg(CFG_RAINBOW_MODE, CFG_DATA_W'($urandom_range(0, 1)));
		write_reg(CFG_FLASH_PERIOD, CFG_DATA_W'(per));
		cfg_we <= 1'b0;
	endtask

	// speed mostly inside the fill range, some at the edges, some anywhere
	function automatic logic [RPM_W-1:0] pick_rpm();
		int lo, hi;
		lo = min_rpm_r;
		hi = flash_rpm_r;
		if (hi <= lo || $urandom_range(0, 5) == 0) begin
			return RPM_W'($urandom_range(0, 32767));
		end
		case ($urandom_range(0, 9))
			0: return RPM_W'(lo);
			1: return RPM_W'(hi);
			2: return RPM_W'((hi < 32767) ? hi + 1 : hi);
			3: return RPM_W'($urandom_range(hi, 32767));
			default: return RPM_W'($urandom_range(lo, hi));
		endcase
	endfunction

	function automatic stim_row_t cfg_row(input logic [CFG_ADDR_W-1:0] a,
			input logic [CFG_DATA_W-1:0] d);
		stim_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.addr = a;
		r.data = d;
		return r;
	endfunction

	function automatic stim_row_t item_row(input logic [RPM_W-1:0] rpm, input logic [7:0] hue,
			input bit blank);
		stim_row_t r;
		r = '0;
		r.kind = ROW_ITEM;
		r.rpm = rpm;
		r.hue = hue;
		r.blank = blank;
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS) begin
				$error("%s: expected %0d, got %0d", name, want, got);
			end
		end
	endtask

	// pixel checker
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pixel_q.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS) begin
					$error("unexpected pixel item for led %0d", out_data.led_index);
				end
			end else begin
				want = pixel_q.pop_front();
				check_field("led_index", want.led_index, out_data.led_index);
				check_field("red", want.red, out_data.red);
				check_field("green", want.green, out_data.green);
				check_field("blue", want.blue, out_data.blue);
				check_field("last_led", want.last_led, out_data.last_led);
			end
		end
	end

	// receiver: stall patterns that change over time, one long hold on request
	initial begin
		int unsigned rx_mode, rx_left, rx_tick;
		rx_mode = 0;
		rx_left = 0;
		rx_tick = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_left = $urandom_range(20, 300);
			end else begin
				rx_left--;
			end
			rx_tick++;
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ($urandom_range(0, 7) == 0);
				default: out_ready <= ((rx_tick % 5) < 2);
			endcase
		end
	end

	// sender and run control
	initial begin
		min_rpm_r = MIN_RPM_RST;
		flash_rpm_r = FLASH_RPM_RST;
		bright_r = BRIGHTNESS_RST;
		rainbow_r = 1'b0;
		period_r = FLASH_PERIOD_RST;
		phase_r = '0;

		// power-on settings: plain bar over 0..12000 rpm, period 50
		frame_table.push_back(item_row(15'd0, 8'h00, 1'b1));
		frame_table.push_back(item_row(15'd6000, 8'h55, 1'b0));
		frame_table.push_back(item_row(15'd12000, 8'hFF, 1'b0));
		frame_table.push_back(item_row(15'd11999, 8'h00, 1'b0));
		frame_table.push_back(item_row(15'd12001, 8'hAA, 1'b1));
		frame_table.push_back(item_row(15'd32767, 8'hFF, 1'b1));
		// short period so the orange flash comes on
		frame_table.push_back(cfg_row(CFG_FLASH_PERIOD, 16'd3));
		frame_table.push_back(item_row(15'd32767, 8'h00, 1'b0));
		frame_table.push_back(item_row(15'd32767, 8'h00, 1'b0));
		frame_table.push_back(item_row(15'd32767, 8'h00, 1'b0));
		// rainbow flash, dimmed floor and linear fade
		frame_table.push_back(cfg_row(CFG_RAINBOW_MODE, 16'd1));
		frame_table.push_back(item_row(15'd32767, 8'h00, 1'b0));
		frame_table.push_back(item_row(15'd32767, 8'hFF, 1'b0));
		frame_table.push_back(item_row(15'd32767, 8'h80, 1'b0));
		frame_table.push_back(item_row(15'd0, 8'd77, 1'b0));
		frame_table.push_back(item_row(15'd6000, 8'd200, 1'b0));
		frame_table.push_back(item_row(15'd12000, 8'd3, 1'b0));
		// zero brightness darkens everything
		frame_table.push_back(cfg_row(CFG_BRIGHTNESS, 16'd0));
		frame_table.push_back(item_row(15'd500, 8'd9, 1'b1));
		frame_table.push_back(item_row(15'd32767, 8'd200, 1'b1));
		// flash rpm at or below the minimum
		frame_table.push_back(cfg_row(CFG_BRIGHTNESS, 16'd1));
		frame_table.push_back(cfg_row(CFG_MIN_RPM, 16'd32767));
		frame_table.push_back(cfg_row(CFG_FLASH_RPM, 16'd1));
		frame_table.push_back(item_row(15'd0, 8'h00, 1'b1));
		frame_table.push_back(item_row(15'd32767, 8'hFF, 1'b0));
		frame_table.push_back(item_row(15'd2, 8'd16, 1'b0));
		// plain bar near both ends of its range, longest period
		frame_table.push_back(cfg_row(CFG_RAINBOW_MODE, 16'd0));
		frame_table.push_back(cfg_row(CFG_BRIGHTNESS, 16'd255));
		frame_table.push_back(cfg_row(CFG_MIN_RPM, 16'd100));
		frame_table.push_back(cfg_row(CFG_FLASH_RPM, 16'd32767));
		frame_table.push_back(cfg_row(CFG_FLASH_PERIOD, 16'hFFFF));
		frame_table.push_back(item_row(15'd100, 8'h00, 1'b1));
		frame_table.push_back(item_row(15'd101, 8'h00, 1'b0));
		frame_table.push_back(item_row(15'd16434, 8'h00, 1'b0));
		frame_table.push_back(item_row(15'd32767, 8'hFF, 1'b0));
		// period lowered below the running phase, speed above the flash rpm
		frame_table.push_back(cfg_row(CFG_FLASH_PERIOD, 16'd2));
		frame_table.push_back(cfg_row(CFG_FLASH_RPM, 16'd30000));
		frame_table.push_back(item_row(15'd32767, 8'h00, 1'b1));
		// periods too short to ever flash
		frame_table.push_back(cfg_row(CFG_FLASH_PERIOD, 16'd0));
		frame_table.push_back(item_row(15'd32767, 8'h00, 1'b1));
		frame_table.push_back(cfg_row(CFG_FLASH_PERIOD, 16'd1));
		frame_table.push_back(item_row(15'd32767, 8'h00, 1'b1));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int k = 0; k < frame_table.size(); k++) begin
			if (frame_table[k].kind == ROW_CFG) begin
				if (k > 0 && frame_table[k - 1].kind == ROW_ITEM) begin
					drain_and_settle();
				end
				write_reg(frame_table[k].addr, frame_table[k].data);
				if (k + 1 >= frame_table.size() || frame_table[k + 1].kind == ROW_ITEM) begin
					cfg_we <= 1'b0;
				end
			end else begin
				send_item(frame_table[k].rpm, frame_table[k].hue, frame_table[k].blank);
			end
		end
		drain_and_settle();

		// random frames under random settings
		for (int p = 0; p < RAND_PHASES; p++) begin
			pick_settings();
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (p == 1 && n == 10) begin
					hold_req = 1'b1;
				end
				if (p == 3 && n == 35) begin
					drain_and_settle();
				end
				send_item(pick_rpm(), 8'($urandom_range(0, 255)), 1'b0);
			end
			drain_and_settle();
		end

		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// watchdog
	initial begin
		#1_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/tlbg_pkg.sv
rtl/tlbg_div.sv
rtl/tlbg_pixel.sv
rtl/tach_led_bar_graph_core.sv
sim/testbench.sv
